@@ rtl/core/nswmp_pkg.sv @@
// Package with the request, response, opcode, status and state types of the name set.
package nswmp_pkg;

  localparam int NAME_W = 40;
  localparam int OCC_W  = 7;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_LEAVE = 2'd1,
    OP_POP   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NAME_W-1:0] name_key;
  } in_req_t;

  typedef struct packed {
    logic [NAME_W-1:0] out_name;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;
  } out_rsp_t;

endpackage

@@ rtl/core/name_set_with_max_pop_unit.sv @@
// Name set with enter, leave by exact name and pop of the greatest name.
// Enter, no-op and requests on an empty table give their result in the cycle after acceptance.
// Leave and pop scan all held names through the single read port of the name memory:
// each read is registered and then compared, and busy stays high until the result appears.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the table; the name memory is not cleared.
module name_set_with_max_pop_unit #(
  parameter int CAPACITY   = 64,
  parameter int NAME_BYTES = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nswmp_pkg::in_req_t  in_req,
  output logic                out_valid,
  output nswmp_pkg::out_rsp_t out_rsp
);

  localparam int KW = (NAME_BYTES >= 5) ? nswmp_pkg::NAME_W : NAME_BYTES * 8;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KW-1:0] mem [CAPACITY];

  nswmp_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       issue_r, issue_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [AW-1:0]       ridx_r, ridx_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       hole_r, hole_nxt;
  logic [KW-1:0]       best_r, best_nxt;
  nswmp_pkg::op_t      op_r, op_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic                out_valid_r, out_valid_nxt;
  nswmp_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;
  logic [KW-1:0]       rdata_r;

  nswmp_pkg::op_t in_op;
  logic [KW-1:0]  in_key;
  logic           upd;
  logic           found_c;
  logic [AW-1:0]  hole_c;
  logic [KW-1:0]  best_c;
  logic           last;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [KW-1:0]  wdata;

  assign in_op  = nswmp_pkg::op_t'(in_req.opcode);
  assign in_key = in_req.name_key[KW-1:0];

  always_comb begin
    if (op_r == nswmp_pkg::OP_LEAVE) begin
      upd = rvalid_r && !found_r && (rdata_r == key_r);
    end else begin
      upd = rvalid_r && (!found_r || (rdata_r > best_r));
    end
    found_c = found_r || upd;
    hole_c  = upd ? ridx_r : hole_r;
    best_c  = upd ? rdata_r : best_r;
    last    = rvalid_r && (CW'(ridx_r) == (count_r - CW'(1)));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nswmp_pkg::S_IDLE: begin
        if (start && (count_r != '0) &&
            ((in_op == nswmp_pkg::OP_LEAVE) || (in_op == nswmp_pkg::OP_POP))) begin
          state_nxt = nswmp_pkg::S_SCAN;
        end
      end
      nswmp_pkg::S_SCAN: begin
        if (last) begin
          state_nxt = nswmp_pkg::S_IDLE;
        end
      end
      default: state_nxt = nswmp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = issue_r[AW-1:0];
    we            = 1'b0;
    waddr         = hole_c;
    wdata         = rdata_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    rvalid_nxt    = 1'b0;
    ridx_nxt      = ridx_r;
    found_nxt     = found_c;
    hole_nxt      = hole_c;
    best_nxt      = best_c;
    op_nxt        = op_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    busy          = (state_r != nswmp_pkg::S_IDLE);
    case (state_r)
      nswmp_pkg::S_IDLE: begin
        if (start) begin
          op_nxt               = in_op;
          key_nxt              = in_key;
          issue_nxt            = '0;
          found_nxt            = 1'b0;
          out_rsp_nxt.out_name = '0;
          out_rsp_nxt.status   = nswmp_pkg::STAT_OK;
          case (in_op)
            nswmp_pkg::OP_ENTER: begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(CAPACITY)) begin
                out_rsp_nxt.status = nswmp_pkg::STAT_FULL;
              end else begin
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = in_key;
                count_nxt = count_r + CW'(1);
              end
            end
            nswmp_pkg::OP_LEAVE: begin
              if (count_r == '0) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = nswmp_pkg::STAT_NOT_FOUND;
              end
            end
            nswmp_pkg::OP_POP: begin
              if (count_r == '0) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = nswmp_pkg::STAT_EMPTY;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      nswmp_pkg::S_SCAN: begin
        if (issue_r < count_r) begin
          rd_en      = 1'b1;
          issue_nxt  = issue_r + CW'(1);
          rvalid_nxt = 1'b1;
          ridx_nxt   = issue_r[AW-1:0];
        end
        if (last) begin
          out_valid_nxt        = 1'b1;
          out_rsp_nxt.out_name = '0;
          out_rsp_nxt.status   = nswmp_pkg::STAT_OK;
          if (found_c) begin
            we        = 1'b1;
            count_nxt = count_r - CW'(1);
            if (op_r == nswmp_pkg::OP_POP) begin
              out_rsp_nxt.out_name = nswmp_pkg::NAME_W'(best_c);
            end
          end else begin
            out_rsp_nxt.status = nswmp_pkg::STAT_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
    out_rsp_nxt.occupancy = nswmp_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nswmp_pkg::S_IDLE;
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rvalid_r    <= rvalid_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r   <= issue_nxt;
    ridx_r    <= ridx_nxt;
    hole_r    <= hole_nxt;
    best_r    <= best_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
